// ===== sv/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants for the trajectory gravity rebake core
// Fixed-point widths and helpers shared by the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none
package tgr_pkg;
    localparam int QW = 16;
    localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;

    // Product of one step of the multiplier: 33-bit by 18-bit operands
    typedef logic signed [32:0] t_opa;
    typedef logic signed [17:0] t_opb;
    typedef logic signed [63:0] t_acc;

    // Round half up by 2^14, floor shift
    function automatic t_acc rnd14(input t_acc v);
        t_acc b;
        b = v + t_acc'(64'sd8192);
        return b >>> 14;
    endfunction

    // Clamp to [-1, 1] in Q2.14
    function automatic logic signed [QW-1:0] clampq(input t_acc v);
        if (v > t_acc'(64'sd16384)) return Q_ONE;
        if (v < t_acc'(-64'sd16384)) return -Q_ONE;
        return v[QW-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/tgr_if.sv =====
// ----------------------------------------------------------------------------
// tgr_in_if / tgr_out_if / tgr_cfg_if: valid/ready channels
// Request channels for keyframes, results and the anchor register.
// ----------------------------------------------------------------------------
`default_nettype none
interface tgr_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] frame_id;
    logic signed [15:0] odom_qw, odom_qx, odom_qy, odom_qz;
    logic signed [31:0] odom_px, odom_py, odom_pz;
    logic signed [15:0] grav_qw, grav_qx, grav_qy, grav_qz;
    modport source (output valid, frame_id, odom_qw, odom_qx, odom_qy, odom_qz,
                    odom_px, odom_py, odom_pz, grav_qw, grav_qx, grav_qy, grav_qz,
                    input ready);
    modport sink (input valid, frame_id, odom_qw, odom_qx, odom_qy, odom_qz,
                  odom_px, odom_py, odom_pz, grav_qw, grav_qx, grav_qy, grav_qz,
                  output ready);
endinterface

interface tgr_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] out_frame_id;
    logic signed [15:0] new_qw, new_qx, new_qy, new_qz;
    logic signed [31:0] new_px, new_py, new_pz;
    modport source (output valid, out_frame_id, new_qw, new_qx, new_qy, new_qz,
                    new_px, new_py, new_pz, input ready);
    modport sink (input valid, out_frame_id, new_qw, new_qx, new_qy, new_qz,
                  new_px, new_py, new_pz, output ready);
endinterface

interface tgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tgr_mac.sv =====
// ----------------------------------------------------------------------------
// tgr_mac: shared multiply-accumulate unit
// One 33x18 signed multiplier with a registered product and a 64-bit
// accumulator; the sequencer feeds one product term per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tgr_mac
    import tgr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,      // operands valid this cycle
    input  wire logic i_neg,     // subtract the term
    input  wire logic i_clr,     // term starts a new sum
    input  wire t_opa i_a,
    input  wire t_opb i_b,
    output      t_acc o_acc
);
    t_acc r_prod;
    logic r_en, r_neg, r_clr;
    t_acc r_acc;

    // Stage 1: product register
    always_ff @(posedge i_clk) begin
        r_prod <= t_acc'(i_a) * t_acc'(i_b);
        r_en   <= i_en;
        r_neg  <= i_neg;
        r_clr  <= i_clr;
    end

    // Stage 2: accumulate
    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_acc <= (r_clr ? t_acc'(0) : r_acc) + (r_neg ? -r_prod : r_prod);
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== sv/trajectory_gravity_rebake_core.sv =====
// ----------------------------------------------------------------------------
// trajectory_gravity_rebake_core: gravity-corrected keyframe trajectory
// One keyframe at a time; all multiplications run on one shared multiplier.
// ----------------------------------------------------------------------------
// A keyframe at or above the anchor id yields one corrected pose. The block
// takes one keyframe, then stays busy. The first keyframe of a run needs 16
// product terms (grav*odom) through the single multiplier and then drains
// the two-stage unit before its result is valid. Later keyframes need 62
// terms (16 for grav*odom, 16 for the last corrected rotation times the
// conjugate of the last odometry rotation, 21 for the 9-entry rotation
// matrix, 9 for the matrix-vector product) and the same drain. The result
// waits in an output register until taken; the block then goes idle before
// it takes the next request, so no keyframe is taken while a result waits.
// Keyframes below the anchor are dropped.
`default_nettype none
module trajectory_gravity_rebake_core
    import tgr_pkg::*;
#(
    parameter int ID_BITS  = 32,
    parameter int POS_BITS = 32
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tgr_in_if.sink    in_if,
    tgr_out_if.source out_if,
    tgr_cfg_if.sink   cfg_if
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;

    // Micro-op kinds: each sum is a list of terms then a write-back
    localparam logic [1:0] WB_NQ  = 2'd0;   // clampq(rnd) into new quat
    localparam logic [1:0] WB_C   = 2'd1;   // clampq(rnd) into C
    localparam logic [1:0] WB_M   = 2'd2;   // rnd into matrix entry
    localparam logic [1:0] WB_P   = 2'd3;   // rnd then add prev pos, saturate

    // id bits that take part in the anchor compare (ports are 32 bits)
    localparam int ID_CMP = (ID_BITS < 32) ? ID_BITS : 32;

    localparam t_acc PHI = (t_acc'(1) <<< (POS_BITS-1)) - t_acc'(1);
    localparam t_acc PLO = -PHI - t_acc'(1);

    logic [2:0]  r_state;
    logic [31:0] r_anchor;
    logic        r_started;
    logic [7:0]  r_pc;          // term counter
    logic [1:0]  r_lat;         // drain counter

    // captured input
    logic [31:0]        r_id;
    logic signed [15:0] r_oq [4];
    logic signed [15:0] r_gq [4];
    logic signed [31:0] r_op [3];
    // state
    logic signed [15:0] r_loq [4];
    logic signed [31:0] r_lop [3];
    logic signed [15:0] r_lnq [4];
    logic signed [POS_BITS-1:0] r_lnp [3];
    // working
    logic signed [15:0] r_nq [4];
    logic signed [15:0] r_c  [4];
    logic signed [17:0] r_m  [9];
    logic signed [POS_BITS-1:0] r_np [3];

    // ---- micro-program decode ----
    // term table: 16 terms for each quaternion product, 21 for the matrix
    // (9 entries; diag entries use a constant term), 9 for the rotate.
    typedef struct packed {
        logic       last;
        logic       neg;
        logic [1:0] wb;
        logic [3:0] dst;
    } t_uop;

    t_uop u;
    t_opa ua;
    t_opb ub;
    logic [7:0] n_end;

    // Saturate to the signed POS_BITS range
    function automatic logic signed [POS_BITS-1:0] satp(input t_acc v);
        if (v > PHI) return PHI[POS_BITS-1:0];
        if (v < PLO) return PLO[POS_BITS-1:0];
        return v[POS_BITS-1:0];
    endfunction

    // quaternion product sign table, term k for component j uses a[i] b[p]
    function automatic logic [4:0] qterm(input logic [3:0] k);
        // returns {neg, ai[1:0], bi[1:0]}
        logic [1:0] j, t;
        j = k[3:2]; t = k[1:0];
        unique case (j)
            2'd0: unique case (t)
                2'd0: return {1'b0, 2'd0, 2'd0};
                2'd1: return {1'b1, 2'd1, 2'd1};
                2'd2: return {1'b1, 2'd2, 2'd2};
                default: return {1'b1, 2'd3, 2'd3};
            endcase
            2'd1: unique case (t)
                2'd0: return {1'b0, 2'd0, 2'd1};
                2'd1: return {1'b0, 2'd1, 2'd0};
                2'd2: return {1'b0, 2'd2, 2'd3};
                default: return {1'b1, 2'd3, 2'd2};
            endcase
            2'd2: unique case (t)
                2'd0: return {1'b0, 2'd0, 2'd2};
                2'd1: return {1'b1, 2'd1, 2'd3};
                2'd2: return {1'b0, 2'd2, 2'd0};
                default: return {1'b0, 2'd3, 2'd1};
            endcase
            default: unique case (t)
                2'd0: return {1'b0, 2'd0, 2'd3};
                2'd1: return {1'b0, 2'd1, 2'd2};
                2'd2: return {1'b1, 2'd2, 2'd1};
                default: return {1'b0, 2'd3, 2'd0};
            endcase
        endcase
    endfunction

    // matrix terms: per entry, a list of (2*)qa*qb products; 28-bit one term
    // encoded as a*b with a=1<<14,b=1<<14 (w-slot 4 means constant 16384)
    // entry layout: {neg, sa[2:0], sb[2:0], last, entry[3:0]}
    function automatic logic [11:0] mterm(input logic [4:0] k);
        unique case (k)
            5'd0:  return {1'b0, 3'd4, 3'd4, 1'b0, 4'd0}; // m0 = one
            5'd1:  return {1'b1, 3'd2, 3'd2, 1'b0, 4'd0}; //  -2yy
            5'd2:  return {1'b1, 3'd3, 3'd3, 1'b1, 4'd0}; //  -2zz
            5'd3:  return {1'b0, 3'd1, 3'd2, 1'b0, 4'd1}; // 2xy
            5'd4:  return {1'b1, 3'd0, 3'd3, 1'b1, 4'd1}; // -2wz
            5'd5:  return {1'b0, 3'd1, 3'd3, 1'b0, 4'd2};
            5'd6:  return {1'b0, 3'd0, 3'd2, 1'b1, 4'd2};
            5'd7:  return {1'b0, 3'd1, 3'd2, 1'b0, 4'd3};
            5'd8:  return {1'b0, 3'd0, 3'd3, 1'b1, 4'd3};
            5'd9:  return {1'b0, 3'd4, 3'd4, 1'b0, 4'd4};
            5'd10: return {1'b1, 3'd1, 3'd1, 1'b0, 4'd4};
            5'd11: return {1'b1, 3'd3, 3'd3, 1'b1, 4'd4};
            5'd12: return {1'b0, 3'd2, 3'd3, 1'b0, 4'd5};
            5'd13: return {1'b1, 3'd0, 3'd1, 1'b1, 4'd5};
            5'd14: return {1'b0, 3'd1, 3'd3, 1'b0, 4'd6};
            5'd15: return {1'b1, 3'd0, 3'd2, 1'b1, 4'd6};
            5'd16: return {1'b0, 3'd2, 3'd3, 1'b0, 4'd7};
            5'd17: return {1'b0, 3'd0, 3'd1, 1'b1, 4'd7};
            5'd18: return {1'b0, 3'd4, 3'd4, 1'b0, 4'd8};
            5'd19: return {1'b1, 3'd1, 3'd1, 1'b0, 4'd8};
            default: return {1'b1, 3'd2, 3'd2, 1'b1, 4'd8};
        endcase
    endfunction

    function automatic t_opb cpick(input logic [2:0] s,
                                   input logic signed [15:0] c0,
                                   input logic signed [15:0] c1,
                                   input logic signed [15:0] c2,
                                   input logic signed [15:0] c3);
        unique case (s)
            3'd0: return 18'(c0);
            3'd1: return 18'(c1);
            3'd2: return 18'(c2);
            3'd3: return 18'(c3);
            default: return 18'sd16384;
        endcase
    endfunction

    // phase boundaries in r_pc
    localparam logic [7:0] P_NQ = 8'd0;    // 16 terms
    localparam logic [7:0] P_C  = 8'd16;   // 16 terms
    localparam logic [7:0] P_M  = 8'd32;   // 21 terms
    localparam logic [7:0] P_R  = 8'd53;   // 9 terms
    localparam logic [7:0] P_E  = 8'd62;

    logic [4:0] qt;
    logic [11:0] mt;
    logic [3:0] rk;
    logic [1:0] ri, rj;
    logic signed [32:0] dsp;
    logic signed [15:0] lconj [4];

    always_comb begin
        lconj[0] = r_loq[0];
        lconj[1] = -r_loq[1];
        lconj[2] = -r_loq[2];
        lconj[3] = -r_loq[3];
        qt = '0; mt = '0; rk = '0; ri = '0; rj = '0; dsp = '0;
        u = '0; ua = '0; ub = '0;
        n_end = r_started ? P_E : P_C;
        if (r_pc < P_C) begin
            qt = qterm(r_pc[3:0]);
            ua = 33'(r_gq[qt[3:2]]);
            ub = 18'(r_oq[qt[1:0]]);
            u  = '{last: (r_pc[1:0] == 2'd3), neg: qt[4], wb: WB_NQ,
                   dst: {2'd0, r_pc[3:2]}};
        end else if (r_pc < P_M) begin
            qt = qterm(4'(r_pc - P_C));
            ua = 33'(r_lnq[qt[3:2]]);
            ub = 18'(lconj[qt[1:0]]);
            u  = '{last: (r_pc[1:0] == 2'd3), neg: qt[4], wb: WB_C,
                   dst: {2'd0, 2'(4'(r_pc - P_C) >> 2)}};
        end else if (r_pc < P_R) begin
            mt = mterm(5'(r_pc - P_M));
            ua = 33'(cpick(mt[10:8], r_c[0], r_c[1], r_c[2], r_c[3]));
            ub = cpick(mt[7:5], r_c[0], r_c[1], r_c[2], r_c[3]);
            if (mt[10:8] != 3'd4) ua = ua <<< 1;    // off-constant terms are doubled
            u  = '{last: mt[4], neg: mt[11], wb: WB_M, dst: mt[3:0]};
        end else begin
            rk = 4'(r_pc - P_R);
            ri = (rk < 4'd3) ? 2'd0 : (rk < 4'd6) ? 2'd1 : 2'd2;
            rj = 2'(rk - 4'(ri) * 4'd3);
            dsp = 33'(r_op[rj]) - 33'(r_lop[rj]);
            ua = dsp;
            ub = r_m[4'(ri) * 4'd3 + 4'(rj)];
            u  = '{last: (rj == 2'd2), neg: 1'b0, wb: WB_P, dst: {2'd0, ri}};
        end
    end

    // ---- shared unit ----
    logic mac_en;
    t_acc acc;
    logic r_first;   // next term starts a sum
    assign mac_en = (r_state == S_RUN) && (r_pc < n_end);

    tgr_mac u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_neg (u.neg),
        .i_clr (r_first),
        .i_a   (ua),
        .i_b   (ub),
        .o_acc (acc)
    );

    // write-back pipeline: matches the two-stage unit latency
    t_uop r_wb1, r_wb2;
    logic r_v1, r_v2;
    t_acc rd;
    t_acc psum;
    assign rd = rnd14(acc);
    assign psum = t_acc'(r_lnp[r_wb2.dst[1:0]]) + rd;

    logic id_lo;
    assign id_lo = in_if.frame_id[ID_CMP-1:0] < r_anchor[ID_CMP-1:0];

    assign in_if.ready  = (r_state == S_IDLE) && !cfg_if.valid;
    assign cfg_if.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_anchor  <= '0;
            r_started <= 1'b0;
            r_pc      <= '0;
            r_lat     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_first   <= 1'b1;
            for (int i = 0; i < 4; i++) begin
                r_loq[i] <= (i == 0) ? Q_ONE : '0;
                r_lnq[i] <= (i == 0) ? Q_ONE : '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_lop[i] <= '0;
                r_lnp[i] <= '0;
            end
        end else begin
            r_v1  <= mac_en && u.last;
            r_wb1 <= u;
            r_v2  <= r_v1;
            r_wb2 <= r_wb1;
            if (mac_en) r_first <= u.last;
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_if.valid) begin
                        r_anchor  <= cfg_if.data;
                        r_started <= 1'b0;
                    end else if (in_if.valid && !id_lo) begin
                        r_id    <= in_if.frame_id;
                        r_oq[0] <= in_if.odom_qw; r_oq[1] <= in_if.odom_qx;
                        r_oq[2] <= in_if.odom_qy; r_oq[3] <= in_if.odom_qz;
                        r_gq[0] <= in_if.grav_qw; r_gq[1] <= in_if.grav_qx;
                        r_gq[2] <= in_if.grav_qy; r_gq[3] <= in_if.grav_qz;
                        r_op[0] <= in_if.odom_px; r_op[1] <= in_if.odom_py;
                        r_op[2] <= in_if.odom_pz;
                        r_pc    <= '0;
                        r_lat   <= '0;
                        r_first <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_pc < n_end) begin
                        r_pc <= r_pc + 8'd1;
                    end else if (r_lat != 2'd2) begin
                        r_lat <= r_lat + 2'd1;
                    end else begin
                        if (!r_started) begin
                            for (int i = 0; i < 3; i++) begin
                                r_np[i] <= satp(t_acc'(r_op[i]));
                            end
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_if.ready) begin
                        r_started <= 1'b1;
                        r_loq <= r_oq;
                        r_lop <= r_op;
                        r_lnq <= r_nq;
                        r_lnp <= r_np;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // write-back of a finished sum
            if (r_v2) begin
                unique case (r_wb2.wb)
                    WB_NQ: r_nq[r_wb2.dst[1:0]] <= clampq(rd);
                    WB_C:  r_c[r_wb2.dst[1:0]]  <= clampq(rd);
                    WB_M:  r_m[r_wb2.dst]       <= rd[17:0];
                    default: r_np[r_wb2.dst[1:0]] <= satp(psum);
                endcase
            end
        end
    end

    // ---- result register ----
    assign out_if.valid        = (r_state == S_OUT);
    assign out_if.out_frame_id = r_id;
    assign out_if.new_qw = r_nq[0];
    assign out_if.new_qx = r_nq[1];
    assign out_if.new_qy = r_nq[2];
    assign out_if.new_qz = r_nq[3];
    assign out_if.new_px = 32'(r_np[0]);
    assign out_if.new_py = 32'(r_np[1]);
    assign out_if.new_pz = 32'(r_np[2]);
endmodule
`default_nettype wire

// ===== sv/tgr_checker.sv =====
// ----------------------------------------------------------------------------
// tgr_checker: port-level checks for the trajectory gravity rebake core
// Watches handshakes on the top level and flags ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none
module tgr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);
    // no new request while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");
    // config only while idle
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !cfg_ready) else $error("config open while busy");
    // no result in the cycle after a request is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    // stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    // an anchor write never produces a result
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_valid && cfg_ready) |=> !out_valid) else $error("result after config");
endmodule

bind trajectory_gravity_rebake_core tgr_checker u_tgr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready)
);
`default_nettype wire

// ===== sim/trajectory_gravity_rebake_core_tb.sv =====
// ----------------------------------------------------------------------------
// trajectory_gravity_rebake_core_tb: self-checking bench for the rebake core
// Drives keyframes and anchor writes and predicts every corrected pose with a
// fixed-point model kept in the bench. Results are checked in order.
// ----------------------------------------------------------------------------
module trajectory_gravity_rebake_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tgr_pkg::*;

    localparam int POS_BITS = 32;

    typedef struct packed {
        logic        [31:0] id;
        logic signed [15:0] oqw, oqx, oqy, oqz;
        logic signed [31:0] opx, opy, opz;
        logic signed [15:0] gqw, gqx, gqy, gqz;
    } keyframe_t;

    typedef struct packed {
        logic        [31:0] id;
        logic signed [15:0] qw, qx, qy, qz;
        logic signed [31:0] px, py, pz;
    } pose_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tgr_in_if  in_if ();
    tgr_out_if out_if ();
    tgr_cfg_if cfg_if ();

    trajectory_gravity_rebake_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (in_if.sink),
        .out_if (out_if.source),
        .cfg_if (cfg_if.sink)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the block state
    logic [31:0]   bench_anchor;
    logic          run_live;
    longint        prev_oq[4], prev_op[3], prev_nq[4], prev_np[3];

    keyframe_t     pending_frames[$];
    pose_t         expected_poses[$];
    int            mismatch_count = 0;
    int            poses_seen = 0;
    int            frames_sent = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_cycles = 0;

    function automatic longint round14(longint v);
        longint b;
        b = v + 64'sd8192;
        return b >>> 14;
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint clip_pos(longint v);
        longint hi;
        hi = (64'sd1 <<< (POS_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void quat_mul(input longint a[4], input longint b[4],
                                     output longint r[4]);
        r[0] = clip_unit(round14(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]));
        r[1] = clip_unit(round14(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]));
        r[2] = clip_unit(round14(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]));
        r[3] = clip_unit(round14(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]));
    endfunction

    // Anchor write restarts the run
    function automatic void anchor_update(logic [31:0] v);
        bench_anchor = v;
        run_live = 1'b0;
    endfunction

    function automatic void bench_reset();
        bench_anchor = '0;
        run_live = 1'b0;
        prev_oq = '{16384, 0, 0, 0};
        prev_nq = '{16384, 0, 0, 0};
        prev_op = '{0, 0, 0};
        prev_np = '{0, 0, 0};
    endfunction

    // Predict the corrected pose of one accepted keyframe
    function automatic void rebake_pose(keyframe_t k);
        longint oq[4], gq[4], op[3], nq[4], np[3], cj[4], c[4], d[3], m[9];
        longint w, x, y, z, one;
        pose_t  p;
        if (k.id < bench_anchor) return;
        oq = '{k.oqw, k.oqx, k.oqy, k.oqz};
        gq = '{k.gqw, k.gqx, k.gqy, k.gqz};
        op = '{k.opx, k.opy, k.opz};
        quat_mul(gq, oq, nq);
        if (!run_live) begin
            for (int i = 0; i < 3; i++) np[i] = clip_pos(op[i]);
            run_live = 1'b1;
        end else begin
            cj = '{prev_oq[0], -prev_oq[1], -prev_oq[2], -prev_oq[3]};
            quat_mul(prev_nq, cj, c);
            for (int i = 0; i < 3; i++) d[i] = op[i] - prev_op[i];
            w = c[0]; x = c[1]; y = c[2]; z = c[3];
            one = 64'sd1 <<< 28;
            m[0] = one - 2*(y*y + z*z);
            m[1] = 2*(x*y - w*z);
            m[2] = 2*(x*z + w*y);
            m[3] = 2*(x*y + w*z);
            m[4] = one - 2*(x*x + z*z);
            m[5] = 2*(y*z - w*x);
            m[6] = 2*(x*z - w*y);
            m[7] = 2*(y*z + w*x);
            m[8] = one - 2*(x*x + y*y);
            for (int i = 0; i < 9; i++) m[i] = round14(m[i]);
            for (int i = 0; i < 3; i++)
                np[i] = clip_pos(prev_np[i] +
                        round14(m[3*i]*d[0] + m[3*i+1]*d[1] + m[3*i+2]*d[2]));
        end
        prev_oq = oq; prev_op = op; prev_nq = nq; prev_np = np;
        p.id = k.id;
        p.qw = nq[0][15:0]; p.qx = nq[1][15:0]; p.qy = nq[2][15:0]; p.qz = nq[3][15:0];
        p.px = np[0][31:0]; p.py = np[1][31:0]; p.pz = np[2][31:0];
        expected_poses.push_back(p);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (pose %0d)", what, got, want,
                 poses_seen);
        mismatch_count++;
    endtask

    // Driver: one request from the queue, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                rebake_pose({in_if.frame_id, in_if.odom_qw, in_if.odom_qx,
                             in_if.odom_qy, in_if.odom_qz, in_if.odom_px,
                             in_if.odom_py, in_if.odom_pz, in_if.grav_qw,
                             in_if.grav_qx, in_if.grav_qy, in_if.grav_qz});
                frames_sent++;
            end
            if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                keyframe_t k;
                k = pending_frames.pop_front();
                in_if.valid    <= 1'b1;
                in_if.frame_id <= k.id;
                in_if.odom_qw  <= k.oqw; in_if.odom_qx <= k.oqx;
                in_if.odom_qy  <= k.oqy; in_if.odom_qz <= k.oqz;
                in_if.odom_px  <= k.opx; in_if.odom_py <= k.opy;
                in_if.odom_pz  <= k.opz;
                in_if.grav_qw  <= k.gqw; in_if.grav_qx <= k.gqx;
                in_if.grav_qy  <= k.gqy; in_if.grav_qz <= k.gqz;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted down one cycle at a time
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // Monitor: check each accepted result, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                pose_t w;
                poses_seen++;
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected pose id", out_if.out_frame_id, -1);
                end else begin
                    w = expected_poses.pop_front();
                    if (out_if.out_frame_id !== w.id)
                        report_mismatch("frame_id", out_if.out_frame_id, w.id);
                    if (out_if.new_qw !== w.qw) report_mismatch("qw", out_if.new_qw, w.qw);
                    if (out_if.new_qx !== w.qx) report_mismatch("qx", out_if.new_qx, w.qx);
                    if (out_if.new_qy !== w.qy) report_mismatch("qy", out_if.new_qy, w.qy);
                    if (out_if.new_qz !== w.qz) report_mismatch("qz", out_if.new_qz, w.qz);
                    if (out_if.new_px !== w.px) report_mismatch("px", out_if.new_px, w.px);
                    if (out_if.new_py !== w.py) report_mismatch("py", out_if.new_py, w.py);
                    if (out_if.new_pz !== w.pz) report_mismatch("pz", out_if.new_pz, w.pz);
                end
            end
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_anchor(logic [31:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        anchor_update(v);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_frames.size() > 0 || in_if.valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_q();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // Roughly unit quaternion about one axis with random sign content
    function automatic void rand_unit(output logic signed [15:0] q[4]);
        int a, c, s;
        a = $urandom_range(3);
        c = $urandom_range(16384);
        s = 16384 - c;
        q = '{0, 0, 0, 0};
        q[0] = 16'($urandom_range(1) ? c : -c);
        q[a == 0 ? 1 : a] = 16'($urandom_range(1) ? s : -s);
        if ($urandom_range(5) == 0)
            for (int i = 0; i < 4; i++) q[i] = rand_q();
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic keyframe_t make_frame(logic [31:0] id);
        keyframe_t k;
        logic signed [15:0] q[4];
        k.id = id;
        rand_unit(q);
        k.oqw = q[0]; k.oqx = q[1]; k.oqy = q[2]; k.oqz = q[3];
        if ($urandom_range(2) == 0) begin
            k.gqw = 16'sd16384; k.gqx = '0; k.gqy = '0; k.gqz = '0;
        end else begin
            rand_unit(q);
            k.gqw = q[0]; k.gqx = q[1]; k.gqy = q[2]; k.gqz = q[3];
        end
        k.opx = rand_pos(); k.opy = rand_pos(); k.opz = rand_pos();
        return k;
    endfunction

    task automatic random_phase(int n, logic [31:0] base);
        logic [31:0] id;
        id = base;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) id = $urandom();
            else id = id + $urandom_range(3);
            pending_frames.push_back(make_frame(id));
        end
    endtask

    initial begin
        keyframe_t k;
        bench_reset();
        in_if.valid = 1'b0;
        in_if.frame_id = '0;
        {in_if.odom_qw, in_if.odom_qx, in_if.odom_qy, in_if.odom_qz} = '0;
        {in_if.odom_px, in_if.odom_py, in_if.odom_pz} = '0;
        {in_if.grav_qw, in_if.grav_qx, in_if.grav_qy, in_if.grav_qz} = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default anchor, identity gravity, extremes, saturation
        k = make_frame(0);
        k.gqw = 16'sd16384; k.gqx = '0; k.gqy = '0; k.gqz = '0;
        pending_frames.push_back(k);
        k = make_frame(1);
        k.opx = 32'sh7fffffff; k.opy = 32'sh80000000; k.opz = '0;
        pending_frames.push_back(k);
        k = make_frame(2);
        k.opx = 32'sh80000000; k.opy = 32'sh7fffffff; k.opz = 32'sh7fffffff;
        pending_frames.push_back(k);
        k = make_frame(3);
        {k.oqw, k.oqx, k.oqy, k.oqz} = {-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
        {k.gqw, k.gqx, k.gqy, k.gqz} = {16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384};
        pending_frames.push_back(k);
        k = make_frame(32'hffffffff);
        pending_frames.push_back(k);
        wait_idle();

        // Anchor in the middle: frames below are dropped, out-of-order id after
        write_anchor(32'd100);
        for (int i = 95; i < 106; i++) pending_frames.push_back(make_frame(32'(i)));
        pending_frames.push_back(make_frame(32'd50));
        pending_frames.push_back(make_frame(32'd120));
        wait_idle();

        // Maximum anchor
        write_anchor(32'hffffffff);
        pending_frames.push_back(make_frame(32'hfffffffe));
        pending_frames.push_back(make_frame(32'hffffffff));
        pending_frames.push_back(make_frame(32'hffffffff));
        wait_idle();

        // Random phase A: sender idles little, receiver a lot, one long hold
        write_anchor(32'd0);
        send_idle_pct = 16; recv_idle_pct = 85;
        hold_cycles = 2000;
        random_phase(200, 32'd0);
        wait_idle();

        write_anchor($urandom_range(1000));
        send_idle_pct = 85; recv_idle_pct = 16;
        random_phase(200, 32'd0);
        wait_idle();

        write_anchor($urandom());
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(200, $urandom());
        wait_idle();

        $display("covered %0d keyframes, %0d poses checked over six anchor settings",
                 frames_sent, poses_seen);
        $display("idling mixes: send-heavy, receive-heavy, none; one long output stall");
        if (mismatch_count == 0) begin
            $display("trajectory_gravity_rebake_core_tb: PASS");
        end else begin
            $display("trajectory_gravity_rebake_core_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("trajectory_gravity_rebake_core_tb: FAIL");
        $finish;
    end
endmodule
